@@ rtl/assert_macros.svh @@
// Assertion macros shared by the complex arithmetic unit RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define CAU_ASSERT_AT(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) prop) else $error(msg);

// Concurrent check on the block clock clk and reset rst_n.
`define CAU_ASSERT(label, prop, msg) \
    `CAU_ASSERT_AT(label, clk, rst_n, prop, msg)

`endif

@@ rtl/cau_pkg.sv @@
// Package for the complex arithmetic unit: widths, opcodes, status codes,
// pipeline word type and the saturation function. No dependencies.
package cau_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CMD_W      = 4;
    localparam int STAT_W     = 2;
    localparam int NUM_W      = WORD_BITS + FRAC_BITS;
    localparam int PROD_W     = 2 * WORD_BITS;
    localparam int WIDE_W     = 2 * WORD_BITS + 2;
    localparam int SQ_REM_W   = WORD_BITS + 2;
    localparam int DIV_STEPS  = NUM_W;
    localparam int ROOT_STEPS = WORD_BITS;

    localparam logic [CMD_W-1:0] OP_CADD  = 4'd0;
    localparam logic [CMD_W-1:0] OP_CSUB  = 4'd1;
    localparam logic [CMD_W-1:0] OP_CMUL  = 4'd2;
    localparam logic [CMD_W-1:0] OP_ADDR  = 4'd3;
    localparam logic [CMD_W-1:0] OP_SUBR  = 4'd4;
    localparam logic [CMD_W-1:0] OP_SCALE = 4'd5;
    localparam logic [CMD_W-1:0] OP_DIVR  = 4'd6;
    localparam logic [CMD_W-1:0] OP_MAG   = 4'd7;
    localparam logic [CMD_W-1:0] OP_RSUBC = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIVZ = 2'd2;

    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic  flag;
        word_t val;
    } sat_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        word_t               res_real;
        word_t               res_imag;
        logic [STAT_W-1:0]   status;
        logic                neg_re;
        logic                neg_im;
        word_t               div_d;
        logic [NUM_W-1:0]    re_nq;
        word_t               re_rem;
        logic [NUM_W-1:0]    im_nq;
        word_t               im_rem;
        logic [PROD_W-1:0]   sq_x;
        logic [SQ_REM_W-1:0] sq_rem;
        word_t               sq_root;
    } pipe_t;

    function automatic sat_t sat_word(logic signed [WIDE_W-1:0] x);
        sat_t r;
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = $signed(WIDE_W'(WORD_MAX));
        lo = -hi - 1;
        if (x > hi)
        begin
            r.flag = 1'b1;
            r.val  = WORD_MAX;
        end
        else if (x < lo)
        begin
            r.flag = 1'b1;
            r.val  = WORD_MIN;
        end
        else
        begin
            r.flag = 1'b0;
            r.val  = x[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/cau_ifs.sv @@
// Valid/ready channel interfaces for operand and result words.
// Depends on cau_pkg.
interface cau_in_if;
    import cau_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [CMD_W-1:0]            command;
    logic signed [WORD_BITS-1:0] a_real;
    logic signed [WORD_BITS-1:0] a_imag;
    logic signed [WORD_BITS-1:0] b_real;
    logic signed [WORD_BITS-1:0] b_imag;
    modport source (output valid, command, a_real, a_imag, b_real, b_imag, input ready);
    modport sink (input valid, command, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
    import cau_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] res_real;
    logic signed [WORD_BITS-1:0] res_imag;
    logic [STAT_W-1:0]           status;
    modport source (output valid, res_real, res_imag, status, input ready);
    modport sink (input valid, res_real, res_imag, status, output ready);
endinterface

@@ rtl/cau_front.sv @@
// Front stages: operand capture, products, add/sub/scale/multiply results,
// divider and square-root setup. Depends on cau_pkg and cau_ifs.
module cau_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    cau_in_if.sink          operands,
    output logic            valid_out,
    output cau_pkg::pipe_t  data_out
);
    import cau_pkg::*;

    // stage 1: operand capture
    logic                        s1_valid_reg;
    logic [CMD_W-1:0]            s1_cmd_reg;
    logic signed [WORD_BITS-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    // stage 2: products and simple results
    logic                        s2_valid_reg;
    logic [CMD_W-1:0]            s2_cmd_reg;
    word_t                       s2_re_reg, s2_im_reg;
    logic [STAT_W-1:0]           s2_status_reg;
    logic signed [PROD_W-1:0]    p0_reg, p1_reg, p2_reg, p3_reg;
    logic                        s2_neg_re_reg, s2_neg_im_reg;
    word_t                       s2_d_reg, s2_mar_reg, s2_mai_reg;

    logic signed [WORD_BITS-1:0] m0_sel, m1_sel;
    logic signed [WIDE_W-1:0]    add_re, add_im;
    sat_t                        sat_re, sat_im;
    word_t                       s2_re_next, s2_im_next;
    logic [STAT_W-1:0]           s2_status_next;

    // stage 3
    logic                        s3_valid_reg;
    pipe_t                       s3_reg, s3_next;
    logic signed [WIDE_W-1:0]    q_re, q_im;
    sat_t                        q_sat_re, q_sat_im;

    assign operands.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= operands.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= operands.command;
            s1_ar_reg  <= operands.a_real;
            s1_ai_reg  <= operands.a_imag;
            s1_br_reg  <= operands.b_real;
            s1_bi_reg  <= operands.b_imag;
        end
    end

    always_comb
    begin
        m0_sel = (s1_cmd_reg == OP_MAG) ? s1_ar_reg : s1_br_reg;
        if (s1_cmd_reg == OP_CMUL)
            m1_sel = s1_bi_reg;
        else if (s1_cmd_reg == OP_MAG)
            m1_sel = s1_ai_reg;
        else
            m1_sel = s1_br_reg;
    end

    always_comb
    begin
        add_re = '0;
        add_im = '0;
        case (s1_cmd_reg)
            OP_CADD:
            begin
                add_re = WIDE_W'(s1_ar_reg) + WIDE_W'(s1_br_reg);
                add_im = WIDE_W'(s1_ai_reg) + WIDE_W'(s1_bi_reg);
            end
            OP_CSUB:
            begin
                add_re = WIDE_W'(s1_ar_reg) - WIDE_W'(s1_br_reg);
                add_im = WIDE_W'(s1_ai_reg) - WIDE_W'(s1_bi_reg);
            end
            OP_ADDR:
            begin
                add_re = WIDE_W'(s1_ar_reg) + WIDE_W'(s1_br_reg);
                add_im = WIDE_W'(s1_ai_reg);
            end
            OP_SUBR:
            begin
                add_re = WIDE_W'(s1_ar_reg) - WIDE_W'(s1_br_reg);
                add_im = WIDE_W'(s1_ai_reg);
            end
            OP_RSUBC:
            begin
                add_re = WIDE_W'(s1_br_reg) - WIDE_W'(s1_ar_reg);
                add_im = -WIDE_W'(s1_ai_reg);
            end
            default:
            begin
                add_re = '0;
                add_im = '0;
            end
        endcase
        sat_re = sat_word(add_re);
        sat_im = sat_word(add_im);
        s2_re_next     = sat_re.val;
        s2_im_next     = sat_im.val;
        s2_status_next = (sat_re.flag || sat_im.flag) ? ST_SAT : ST_OK;
        if (s1_cmd_reg == OP_DIVR && s1_br_reg == '0)
        begin
            s2_re_next     = s1_ar_reg[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
            s2_im_next     = s1_ai_reg[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
            s2_status_next = ST_DIVZ;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_cmd_reg    <= s1_cmd_reg;
            s2_re_reg     <= s2_re_next;
            s2_im_reg     <= s2_im_next;
            s2_status_reg <= s2_status_next;
            p0_reg        <= PROD_W'(s1_ar_reg) * PROD_W'(m0_sel);
            p1_reg        <= PROD_W'(s1_ai_reg) * PROD_W'(m1_sel);
            p2_reg        <= PROD_W'(s1_ar_reg) * PROD_W'(s1_bi_reg);
            p3_reg        <= PROD_W'(s1_ai_reg) * PROD_W'(s1_br_reg);
            s2_neg_re_reg <= s1_ar_reg[WORD_BITS-1] ^ s1_br_reg[WORD_BITS-1];
            s2_neg_im_reg <= s1_ai_reg[WORD_BITS-1] ^ s1_br_reg[WORD_BITS-1];
            s2_d_reg      <= s1_br_reg[WORD_BITS-1] ? word_t'(-s1_br_reg) : word_t'(s1_br_reg);
            s2_mar_reg    <= s1_ar_reg[WORD_BITS-1] ? word_t'(-s1_ar_reg) : word_t'(s1_ar_reg);
            s2_mai_reg    <= s1_ai_reg[WORD_BITS-1] ? word_t'(-s1_ai_reg) : word_t'(s1_ai_reg);
        end
    end

    always_comb
    begin
        case (s2_cmd_reg)
            OP_CMUL:
            begin
                q_re = (WIDE_W'(p0_reg) - WIDE_W'(p1_reg)) >>> FRAC_BITS;
                q_im = (WIDE_W'(p2_reg) + WIDE_W'(p3_reg)) >>> FRAC_BITS;
            end
            default:
            begin
                q_re = WIDE_W'(p0_reg) >>> FRAC_BITS;
                q_im = WIDE_W'(p1_reg) >>> FRAC_BITS;
            end
        endcase
        q_sat_re = sat_word(q_re);
        q_sat_im = sat_word(q_im);

        s3_next.cmd      = s2_cmd_reg;
        s3_next.res_real = s2_re_reg;
        s3_next.res_imag = s2_im_reg;
        s3_next.status   = s2_status_reg;
        if (s2_cmd_reg == OP_CMUL || s2_cmd_reg == OP_SCALE)
        begin
            s3_next.res_real = q_sat_re.val;
            s3_next.res_imag = q_sat_im.val;
            s3_next.status   = (q_sat_re.flag || q_sat_im.flag) ? ST_SAT : ST_OK;
        end
        s3_next.neg_re  = s2_neg_re_reg;
        s3_next.neg_im  = s2_neg_im_reg;
        s3_next.div_d   = s2_d_reg;
        s3_next.re_nq   = {s2_mar_reg, {FRAC_BITS{1'b0}}};
        s3_next.re_rem  = '0;
        s3_next.im_nq   = {s2_mai_reg, {FRAC_BITS{1'b0}}};
        s3_next.im_rem  = '0;
        // both squares are nonnegative, so the sum fits unsigned
        s3_next.sq_x    = PROD_W'(p0_reg) + PROD_W'(p1_reg);
        s3_next.sq_rem  = '0;
        s3_next.sq_root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s3_reg <= s3_next;
    end

    assign valid_out = s3_valid_reg;
    assign data_out  = s3_reg;

endmodule

@@ rtl/cau_step.sv @@
// One iteration stage: a restoring-division step on both quotient lanes and,
// when enabled, one digit of the integer square root. Depends on cau_pkg.
module cau_step
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            root_en,
    input  logic            valid_in,
    input  cau_pkg::pipe_t  data_in,
    output logic            valid_out,
    output cau_pkg::pipe_t  data_out
);
    import cau_pkg::*;

    logic                  valid_reg;
    pipe_t                 data_reg, data_next;
    logic [WORD_BITS:0]    re_r2, im_r2, d_ext;
    logic                  re_ge, im_ge;
    logic [SQ_REM_W+1:0]   sq_r2, sq_trial;
    logic                  sq_ge;

    always_comb
    begin
        data_next = data_in;
        d_ext = {1'b0, data_in.div_d};

        re_r2 = {data_in.re_rem, data_in.re_nq[NUM_W-1]};
        re_ge = re_r2 >= d_ext;
        data_next.re_rem = re_ge ? WORD_BITS'(re_r2 - d_ext) : WORD_BITS'(re_r2);
        data_next.re_nq  = {data_in.re_nq[NUM_W-2:0], re_ge};

        im_r2 = {data_in.im_rem, data_in.im_nq[NUM_W-1]};
        im_ge = im_r2 >= d_ext;
        data_next.im_rem = im_ge ? WORD_BITS'(im_r2 - d_ext) : WORD_BITS'(im_r2);
        data_next.im_nq  = {data_in.im_nq[NUM_W-2:0], im_ge};

        sq_r2    = {data_in.sq_rem, data_in.sq_x[PROD_W-1 -: 2]};
        sq_trial = (SQ_REM_W+2)'({data_in.sq_root, 2'b01});
        sq_ge    = sq_r2 >= sq_trial;
        if (root_en)
        begin
            data_next.sq_rem  = sq_ge ? SQ_REM_W'(sq_r2 - sq_trial) : SQ_REM_W'(sq_r2);
            data_next.sq_root = {data_in.sq_root[WORD_BITS-2:0], sq_ge};
            data_next.sq_x    = {data_in.sq_x[PROD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ rtl/cau_back.sv @@
// Final stage: quotient sign and saturation, root clamp, result select and
// output register; owns the pipeline advance. Depends on cau_pkg and cau_ifs.
module cau_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  cau_pkg::pipe_t  data_in,
    output logic            adv,
    cau_out_if.source       results
);
    import cau_pkg::*;

    logic                     out_valid_reg;
    word_t                    re_reg, im_reg, re_next, im_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic signed [WIDE_W-1:0] qu_re, qu_im, qs_re, qs_im;
    sat_t                     qsat_re, qsat_im;

    assign adv = !out_valid_reg || results.ready;

    always_comb
    begin
        qu_re = $signed(WIDE_W'(data_in.re_nq));
        qu_im = $signed(WIDE_W'(data_in.im_nq));
        qs_re = data_in.neg_re ? -qu_re : qu_re;
        qs_im = data_in.neg_im ? -qu_im : qu_im;
        qsat_re = sat_word(qs_re);
        qsat_im = sat_word(qs_im);

        re_next     = data_in.res_real;
        im_next     = data_in.res_imag;
        status_next = data_in.status;
        case (data_in.cmd)
            OP_DIVR:
            begin
                if (data_in.status != ST_DIVZ)
                begin
                    re_next     = qsat_re.val;
                    im_next     = qsat_im.val;
                    status_next = (qsat_re.flag || qsat_im.flag) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG:
            begin
                im_next = '0;
                if (data_in.sq_root[WORD_BITS-1])
                begin
                    re_next     = WORD_MAX;
                    status_next = ST_SAT;
                end
                else
                begin
                    re_next     = data_in.sq_root;
                    status_next = ST_OK;
                end
            end
            OP_CADD, OP_CSUB, OP_CMUL, OP_ADDR, OP_SUBR, OP_SCALE, OP_RSUBC:
            begin
                re_next = data_in.res_real;
            end
            default:
            begin
                re_next     = '0;
                im_next     = '0;
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re_reg     <= re_next;
            im_reg     <= im_next;
            status_reg <= status_next;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.res_real = re_reg;
    assign results.res_imag = im_reg;
    assign results.status   = status_reg;

endmodule

@@ rtl/complex_arithmetic_unit.sv @@
// Throughput: one word per cycle; a stalled output freezes the whole pipeline.
// Depth is set by the 48 restoring-division steps (one quotient bit a stage).
// Reset (rst_n, async, active low) clears all valid bits; no state is kept.
// Depends on cau_pkg, cau_ifs, cau_front, cau_step, cau_back.
`include "assert_macros.svh"

module complex_arithmetic_unit
(
    input  logic      clk,
    input  logic      rst_n,
    cau_in_if.sink    operands,
    cau_out_if.source results
);
    import cau_pkg::*;

    logic  adv;
    logic  step_valid [DIV_STEPS+1];
    pipe_t step_data  [DIV_STEPS+1];

    cau_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .operands  (operands),
        .valid_out (step_valid[0]),
        .data_out  (step_data[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        cau_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .root_en   (i < ROOT_STEPS),
            .valid_in  (step_valid[i]),
            .data_in   (step_data[i]),
            .valid_out (step_valid[i+1]),
            .data_out  (step_data[i+1])
        );
    end

    cau_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (step_valid[DIV_STEPS]),
        .data_in  (step_data[DIV_STEPS]),
        .adv      (adv),
        .results  (results)
    );

    `CAU_ASSERT(a_stall_blocks_input, (results.valid && !results.ready) |-> !operands.ready, "input accepted while output stalled")
    `CAU_ASSERT(a_status_code, results.valid |-> (results.status != 2'd3), "undefined status code")
    `CAU_ASSERT(a_divz_limits, (results.valid && results.status == ST_DIVZ) |-> ((results.res_real == WORD_MAX || results.res_real == WORD_MIN) && (results.res_imag == WORD_MAX || results.res_imag == WORD_MIN)), "division by zero result not at a limit")

endmodule

@@ tb/complex_arithmetic_unit_tb.sv @@
// Testbench for the complex arithmetic unit: directed table plus random words,
// checked against an in-bench fixed-point predictor. Depends on cau_pkg, cau_ifs, complex_arithmetic_unit.
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        word_t             ar;
        word_t             ai;
        word_t             br;
        word_t             bi;
        logic              known;
        word_t             er;
        word_t             ei;
        logic [STAT_W-1:0] es;
    } op_row_t;

    typedef struct {
        word_t             re;
        word_t             im;
        logic [STAT_W-1:0] st;
    } cres_t;

    logic clk;
    logic rst_n;
    cau_in_if  operands ();
    cau_out_if results ();

    complex_arithmetic_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .operands(operands.sink),
        .results(results.source)
    );

    cres_t   expected_q[$];
    op_row_t dir_rows[$];
    int      mismatches;
    int      words_out;
    int      src_idle;
    int      snk_idle;
    logic    no_idle;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [65:0] clamp_part(logic signed [129:0] x, ref logic hit);
        logic signed [129:0] hi;
        logic signed [129:0] lo;
        hi = 130'sh7fffffff;
        lo = -hi - 1;
        if (x > hi)
        begin
            hit = 1'b1;
            return 66'sh7fffffff;
        end
        if (x < lo)
        begin
            hit = 1'b1;
            return -66'sh80000000;
        end
        return x[65:0];
    endfunction

    function automatic logic signed [129:0] quot_part(logic signed [31:0] a,
                                                      logic signed [31:0] b);
        logic signed [129:0] n;
        logic signed [129:0] d;
        n = 130'(a) <<< FRAC_BITS;
        d = 130'(b);
        return n / d;
    endfunction

    function automatic cres_t predict_complex(logic [CMD_W-1:0] cmd, word_t ar_w, word_t ai_w,
                                              word_t br_w, word_t bi_w);
        cres_t r;
        logic hit;
        logic signed [129:0] ar;
        logic signed [129:0] ai;
        logic signed [129:0] br;
        logic signed [129:0] bi;
        logic signed [129:0] t;
        logic [127:0] sq;
        logic [63:0] root;
        hit = 1'b0;
        ar = 130'($signed(ar_w));
        ai = 130'($signed(ai_w));
        br = 130'($signed(br_w));
        bi = 130'($signed(bi_w));
        r.re = '0;
        r.im = '0;
        r.st = ST_OK;
        case (cmd)
            OP_CADD:
            begin
                r.re = word_t'(clamp_part(ar + br, hit));
                r.im = word_t'(clamp_part(ai + bi, hit));
            end
            OP_CSUB:
            begin
                r.re = word_t'(clamp_part(ar - br, hit));
                r.im = word_t'(clamp_part(ai - bi, hit));
            end
            OP_CMUL:
            begin
                t = (ar * br - ai * bi) >>> FRAC_BITS;
                r.re = word_t'(clamp_part(t, hit));
                t = (ar * bi + ai * br) >>> FRAC_BITS;
                r.im = word_t'(clamp_part(t, hit));
            end
            OP_ADDR:
            begin
                r.re = word_t'(clamp_part(ar + br, hit));
                r.im = ai_w;
            end
            OP_SUBR:
            begin
                r.re = word_t'(clamp_part(ar - br, hit));
                r.im = ai_w;
            end
            OP_SCALE:
            begin
                r.re = word_t'(clamp_part((ar * br) >>> FRAC_BITS, hit));
                r.im = word_t'(clamp_part((ai * br) >>> FRAC_BITS, hit));
            end
            OP_DIVR:
            begin
                if (br_w == '0)
                begin
                    r.re = ar_w[31] ? WORD_MIN : WORD_MAX;
                    r.im = ai_w[31] ? WORD_MIN : WORD_MAX;
                    r.st = ST_DIVZ;
                end
                else
                begin
                    r.re = word_t'(clamp_part(quot_part(ar_w, br_w), hit));
                    r.im = word_t'(clamp_part(quot_part(ai_w, br_w), hit));
                end
            end
            OP_MAG:
            begin
                sq = 128'(ar * ar + ai * ai);
                root = '0;
                for (int i = 63; i >= 0; i--)
                begin
                    if (128'(root | (64'd1 << i)) * 128'(root | (64'd1 << i)) <= sq)
                        root = root | (64'd1 << i);
                end
                if (root > 64'h7fffffff)
                begin
                    root = 64'h7fffffff;
                    hit = 1'b1;
                end
                r.re = root[31:0];
            end
            OP_RSUBC:
            begin
                r.re = word_t'(clamp_part(br - ar, hit));
                r.im = word_t'(clamp_part(-ai, hit));
            end
            default:
            begin
            end
        endcase
        if (r.st == ST_OK && hit)
            r.st = ST_SAT;
        return r;
    endfunction

    function automatic word_t rand_part();
        case ($urandom_range(0, 7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return word_t'($urandom_range(0, 3)) - 1;
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            4: return word_t'(32'sd65536 * ($signed(32'($urandom_range(0, 20))) - 10));
            default: return $urandom;
        endcase
    endfunction

    function automatic op_row_t mk_row(logic [CMD_W-1:0] cmd, word_t ar, word_t ai, word_t br,
                                       word_t bi, logic known = 1'b0, word_t er = '0,
                                       word_t ei = '0, logic [STAT_W-1:0] es = ST_OK);
        op_row_t w;
        w = '{cmd, ar, ai, br, bi, known, er, ei, es};
        return w;
    endfunction

    task automatic send_word(op_row_t w);
        cres_t p;
        while (!no_idle && $urandom_range(0, 99) < src_idle)
        begin
            operands.valid <= 1'b0;
            @(posedge clk);
        end
        operands.valid   <= 1'b1;
        operands.command <= w.cmd;
        operands.a_real  <= w.ar;
        operands.a_imag  <= w.ai;
        operands.b_real  <= w.br;
        operands.b_imag  <= w.bi;
        p = predict_complex(w.cmd, w.ar, w.ai, w.br, w.bi);
        if (w.known)
        begin
            p.re = w.er;
            p.im = w.ei;
            p.st = w.es;
        end
        @(posedge clk);
        while (!operands.ready)
            @(posedge clk);
        expected_q.push_back(p);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (results.valid && results.ready)
            begin
                cres_t e;
                words_out++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h %h %0d",
                                 results.res_real, results.res_imag, results.status);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (results.res_real !== e.re || results.res_imag !== e.im
                        || results.status !== e.st)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h %h %0d got %h %h %0d", e.re, e.im,
                                     e.st, results.res_real, results.res_imag,
                                     results.status);
                    end
                end
            end
            results.ready <= no_idle || ($urandom_range(0, 99) >= snk_idle);
        end
    end

    initial
    begin
        #20ms;
        $display("FAIL complex_arithmetic_unit");
        $finish;
    end

    initial
    begin
        op_row_t w;
        int n_sent;
        int phase_len;
        clk = 1'b0;
        rst_n = 1'b0;
        operands.valid = 1'b0;
        operands.command = '0;
        operands.a_real = '0;
        operands.a_imag = '0;
        operands.b_real = '0;
        operands.b_imag = '0;
        results.ready = 1'b0;
        mismatches = 0;
        words_out = 0;
        n_sent = 0;
        src_idle = 10;
        snk_idle = 59;
        no_idle = 1'b0;

        dir_rows.push_back(mk_row(OP_CADD, 0, 0, 0, 0, 1, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(OP_CADD, WORD_MAX, WORD_MIN, 1, -1, 1, WORD_MAX, WORD_MIN,
                                  ST_SAT));
        dir_rows.push_back(mk_row(OP_CSUB, WORD_MIN, WORD_MAX, 1, -1, 1, WORD_MIN, WORD_MAX,
                                  ST_SAT));
        dir_rows.push_back(mk_row(OP_CSUB, 5, 7, 2, 3, 1, 3, 4, ST_OK));
        dir_rows.push_back(mk_row(OP_CMUL, 32'h10000, 32'h20000, 32'h30000, -32'sh10000));
        dir_rows.push_back(mk_row(OP_CMUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX));
        dir_rows.push_back(mk_row(OP_CMUL, -1, 0, 1, 0));
        dir_rows.push_back(mk_row(OP_ADDR, WORD_MAX, 9, 1, 77, 1, WORD_MAX, 9, ST_SAT));
        dir_rows.push_back(mk_row(OP_SUBR, WORD_MIN, WORD_MIN, 1, 3, 1, WORD_MIN, WORD_MIN,
                                  ST_SAT));
        dir_rows.push_back(mk_row(OP_SCALE, 32'h18000, -32'sh8000, 32'h20000, 0));
        dir_rows.push_back(mk_row(OP_SCALE, WORD_MAX, WORD_MIN, WORD_MIN, 0));
        dir_rows.push_back(mk_row(OP_DIVR, 5, -5, 0, 1, 1, WORD_MAX, WORD_MIN, ST_DIVZ));
        dir_rows.push_back(mk_row(OP_DIVR, 0, WORD_MIN, 0, 0, 1, WORD_MAX, WORD_MIN, ST_DIVZ));
        dir_rows.push_back(mk_row(OP_DIVR, 32'h30000, -32'sh30000, -32'sh20000, 0));
        dir_rows.push_back(mk_row(OP_DIVR, WORD_MIN, WORD_MAX, 1, 0));
        dir_rows.push_back(mk_row(OP_DIVR, WORD_MIN, 1, -1, 0));
        dir_rows.push_back(mk_row(OP_MAG, 32'h30000, 32'h40000, 0, 0));
        dir_rows.push_back(mk_row(OP_MAG, WORD_MIN, WORD_MIN, 0, 0));
        dir_rows.push_back(mk_row(OP_MAG, 0, 0, 0, 0, 1, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(OP_RSUBC, WORD_MIN, WORD_MIN, 0, 0, 1, WORD_MAX, WORD_MAX,
                                  ST_SAT));
        dir_rows.push_back(mk_row(OP_RSUBC, 1, 2, 10, 0, 1, 9, -2, ST_OK));
        dir_rows.push_back(mk_row(4'd9, 1, 2, 3, 4, 1, 0, 0, ST_OK));
        dir_rows.push_back(mk_row(4'd15, -1, -1, -1, -1, 1, 0, 0, ST_OK));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i]);
        n_sent = dir_rows.size();

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle = (ph == 0) ? 10 : 59;
            snk_idle = (ph == 0) ? 59 : 10;
            no_idle  = (ph == 2);
            phase_len = 650;
            for (int k = 0; k < phase_len; k++)
            begin
                w = mk_row(CMD_W'($urandom_range(0, 99) < 95 ? $urandom_range(0, 8)
                                                             : $urandom_range(9, 15)),
                           rand_part(), rand_part(), rand_part(), rand_part());
                if (w.cmd == OP_DIVR && $urandom_range(0, 19) == 0)
                    w.br = '0;
                send_word(w);
                n_sent++;
                if (k == 300)
                begin
                    operands.valid <= 1'b0;
                    while (expected_q.size() != 0)
                        @(posedge clk);
                end
            end
        end

        operands.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("covered %0d operand words, all opcodes incl. undefined, saturation and",
                 n_sent);
        $display("division by zero, with %0d result words checked under varied stalls",
                 words_out);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASS complex_arithmetic_unit");
        else
            $display("FAIL complex_arithmetic_unit");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_ifs.sv
rtl/cau_front.sv
rtl/cau_step.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_tb.sv
